### hdl/dotp_pkg.sv
// ----------------------------------------------------------------------------
// dotp_pkg
// Shared types, option codes and helpers for the DHCP option TLV parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dotp_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int VALUE_SLOTS = 7;

    localparam logic [7:0] CODE_PAD      = 8'd0;
    localparam logic [7:0] CODE_SUBNET   = 8'd1;
    localparam logic [7:0] CODE_ROUTER   = 8'd3;
    localparam logic [7:0] CODE_DNS      = 8'd6;
    localparam logic [7:0] CODE_LEASE    = 8'd51;
    localparam logic [7:0] CODE_MSG_TYPE = 8'd53;
    localparam logic [7:0] CODE_SERVER   = 8'd54;
    localparam logic [7:0] CODE_T1       = 8'd58;
    localparam logic [7:0] CODE_T2       = 8'd59;
    localparam logic [7:0] CODE_END      = 8'd255;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_TYPE  = 2'd1,
        STATUS_NO_LEN   = 2'd2,
        STATUS_OVERRUN  = 2'd3
    } status_t;

    // where a finished option lands in the back end
    typedef enum logic [2:0] {
        KIND_SUBNET = 3'd0,
        KIND_ROUTER = 3'd1,
        KIND_DNS    = 3'd2,
        KIND_LEASE  = 3'd3,
        KIND_SERVER = 3'd4,
        KIND_T1     = 3'd5,
        KIND_T2     = 3'd6,
        KIND_MSG    = 3'd7
    } kind_t;

    typedef struct packed {
        logic        commit;
        kind_t       kind;
        logic [31:0] value;
        logic        last;
        status_t     err;
    } op_t;

    typedef struct packed {
        logic is_slot;
        kind_t kind;
    } slot_info_t;

    function automatic slot_info_t slot_of(input logic [7:0] code);
        slot_info_t r;
        r.is_slot = 1'b1;
        r.kind    = KIND_SUBNET;
        case (code)
            CODE_SUBNET: r.kind = KIND_SUBNET;
            CODE_ROUTER: r.kind = KIND_ROUTER;
            CODE_DNS:    r.kind = KIND_DNS;
            CODE_LEASE:  r.kind = KIND_LEASE;
            CODE_SERVER: r.kind = KIND_SERVER;
            CODE_T1:     r.kind = KIND_T1;
            CODE_T2:     r.kind = KIND_T2;
            default:     r.is_slot = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/dhcp_option_tlv_parser_unit.sv
// ----------------------------------------------------------------------------
// dhcp_option_tlv_parser_unit
// DHCP option stream parser: one byte per cycle in, one result per stream out.
// ----------------------------------------------------------------------------
// The block takes one option byte per clock cycle while s_ready is high, with
// no gaps needed between bytes or streams. The framing stage handles each
// accepted byte and posts a transaction to a four-entry queue only when a
// captured option completes or the stream ends; the capture stage drains that
// queue one per cycle, but a last-byte transaction waits for the output
// register to be free, then loads the result there and raises m_valid.
// s_ready drops only when the queue fills because a finished result is not
// taken.
`default_nettype none

module dhcp_option_tlv_parser_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [7:0]       m_message_type,
    output logic [31:0]      m_subnet_mask,
    output logic [31:0]      m_router_address,
    output logic [31:0]      m_dns_address,
    output logic [31:0]      m_lease_seconds,
    output logic [31:0]      m_server_address,
    output logic [31:0]      m_renewal_seconds,
    output logic [31:0]      m_rebinding_seconds
);
    import dotp_pkg::*;

    logic q_push, q_pop, q_full, q_empty;
    op_t  push_op, head_op;

    dotp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_op        (push_op)
    );

    dotp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_op (push_op),
        .pop     (q_pop),
        .full    (q_full),
        .empty   (q_empty),
        .head_op (head_op)
    );

    dotp_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .q_empty             (q_empty),
        .q_head              (head_op),
        .q_pop               (q_pop),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_message_type      (m_message_type),
        .m_subnet_mask       (m_subnet_mask),
        .m_router_address    (m_router_address),
        .m_dns_address       (m_dns_address),
        .m_lease_seconds     (m_lease_seconds),
        .m_server_address    (m_server_address),
        .m_renewal_seconds   (m_renewal_seconds),
        .m_rebinding_seconds (m_rebinding_seconds)
    );

endmodule

`default_nettype wire

### hdl/dotp_front.sv
// ----------------------------------------------------------------------------
// dotp_front
// Walks the code / length / data framing and posts capture operations.
// ----------------------------------------------------------------------------
`default_nettype none

module dotp_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_data_byte,
    input  wire logic          s_last_byte,
    input  wire logic          q_full,
    output logic               q_push,
    output dotp_pkg::op_t      q_op
);
    import dotp_pkg::*;

    typedef enum logic [1:0] {
        PH_CODE  = 2'd0,
        PH_LEN   = 2'd1,
        PH_DATA  = 2'd2,
        PH_ENDED = 2'd3
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  len_reg, len_next;
    logic [2:0]  idx_reg, idx_next;
    logic [31:0] acc_reg, acc_next;
    logic [7:0]  first_reg, first_next;
    logic        accept;
    slot_info_t  slot;
    op_t         op;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign slot    = slot_of(code_reg);

    always_comb begin
        phase_next = phase_reg;
        code_next  = code_reg;
        rem_next   = rem_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        first_next = first_reg;
        op.commit  = 1'b0;
        op.kind    = KIND_MSG;
        op.value   = 32'd0;
        op.last    = s_last_byte;
        op.err     = STATUS_OK;
        case (phase_reg)
            PH_CODE: begin
                if (s_data_byte == CODE_END) begin
                    phase_next = PH_ENDED;
                end else if (s_data_byte != CODE_PAD) begin
                    code_next  = s_data_byte;
                    phase_next = PH_LEN;
                    if (s_last_byte) op.err = STATUS_NO_LEN;
                end
            end
            PH_LEN: begin
                len_next = s_data_byte;
                rem_next = s_data_byte;
                idx_next = 3'd0;
                acc_next = 32'd0;
                // a zero-length option captures nothing
                if (s_data_byte == 8'd0) begin
                    phase_next = PH_CODE;
                end else begin
                    phase_next = PH_DATA;
                    if (s_last_byte) op.err = STATUS_OVERRUN;
                end
            end
            PH_DATA: begin
                if (!idx_reg[2]) begin
                    acc_next = {acc_reg[23:0], s_data_byte};
                    idx_next = idx_reg + 3'd1;
                end
                if (idx_reg == 3'd0) first_next = s_data_byte;
                rem_next = rem_reg - 8'd1;
                if (rem_next == 8'd0) begin
                    phase_next = PH_CODE;
                    if (code_reg == CODE_MSG_TYPE) begin
                        op.commit = 1'b1;
                        op.kind   = KIND_MSG;
                        op.value  = {24'd0, first_next};
                    end else if (slot.is_slot && len_reg >= 8'd4) begin
                        op.commit = 1'b1;
                        op.kind   = slot.kind;
                        op.value  = acc_next;
                    end
                end else if (s_last_byte) begin
                    op.err = STATUS_OVERRUN;
                end
            end
            default: begin
            end
        endcase
    end

    assign q_push = accept && (op.commit || s_last_byte);
    assign q_op   = op;

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_last_byte)) begin
            phase_reg <= PH_CODE;
            code_reg  <= 8'd0;
            rem_reg   <= 8'd0;
            len_reg   <= 8'd0;
            idx_reg   <= 3'd0;
            acc_reg   <= 32'd0;
            first_reg <= 8'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            code_reg  <= code_next;
            rem_reg   <= rem_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            acc_reg   <= acc_next;
            first_reg <= first_next;
        end
    end

endmodule

`default_nettype wire

### hdl/dotp_queue.sv
// ----------------------------------------------------------------------------
// dotp_queue
// Small FIFO of capture operations between the framing and capture stages.
// ----------------------------------------------------------------------------
`default_nettype none

module dotp_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire dotp_pkg::op_t push_op,
    input  wire logic          pop,
    output logic               full,
    output logic               empty,
    output dotp_pkg::op_t      head_op
);
    import dotp_pkg::*;

    op_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  do_push, do_pop;

    assign full    = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head_op = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) count_next = count_reg + 1'b1;
        if (do_pop && !do_push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) entry_reg[wr_ptr_reg] <= push_op;
    end

endmodule

`default_nettype wire

### hdl/dotp_back.sv
// ----------------------------------------------------------------------------
// dotp_back
// Holds captured values and builds the per-stream result.
// ----------------------------------------------------------------------------
`default_nettype none

module dotp_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_empty,
    input  wire dotp_pkg::op_t q_head,
    output logic               q_pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [1:0]         m_status,
    output logic [7:0]         m_message_type,
    output logic [31:0]        m_subnet_mask,
    output logic [31:0]        m_router_address,
    output logic [31:0]        m_dns_address,
    output logic [31:0]        m_lease_seconds,
    output logic [31:0]        m_server_address,
    output logic [31:0]        m_renewal_seconds,
    output logic [31:0]        m_rebinding_seconds
);
    import dotp_pkg::*;

    logic [31:0] held_reg [VALUE_SLOTS];
    logic [31:0] held_next [VALUE_SLOTS];
    logic [7:0]  msg_reg, msg_next;
    logic        m_valid_reg;
    logic [1:0]  status_reg;
    logic [7:0]  msg_out_reg;
    logic [31:0] value_out_reg [VALUE_SLOTS];
    status_t     status_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;
    // a last-byte transaction waits for the output register, captures never do
    assign q_pop    = !q_empty && (!q_head.last || out_free);

    always_comb begin
        for (int i = 0; i < VALUE_SLOTS; i++) held_next[i] = held_reg[i];
        msg_next = msg_reg;
        if (q_head.commit) begin
            if (q_head.kind == KIND_MSG) begin
                msg_next = q_head.value[7:0];
            end else begin
                held_next[q_head.kind] = q_head.value;
            end
        end
        if (q_head.err != STATUS_OK) begin
            status_next = q_head.err;
        end else if (msg_next == 8'd0) begin
            status_next = STATUS_NO_TYPE;
        end else begin
            status_next = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            msg_reg     <= 8'd0;
            for (int i = 0; i < VALUE_SLOTS; i++) held_reg[i] <= 32'd0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (q_pop) begin
                if (q_head.last) begin
                    m_valid_reg <= 1'b1;
                    msg_reg     <= 8'd0;
                    for (int i = 0; i < VALUE_SLOTS; i++) held_reg[i] <= 32'd0;
                end else begin
                    msg_reg <= msg_next;
                    for (int i = 0; i < VALUE_SLOTS; i++) held_reg[i] <= held_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_head.last) begin
            status_reg  <= status_next;
            msg_out_reg <= msg_next;
            for (int i = 0; i < VALUE_SLOTS; i++) value_out_reg[i] <= held_next[i];
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_status            = status_reg;
    assign m_message_type      = msg_out_reg;
    assign m_subnet_mask       = value_out_reg[KIND_SUBNET];
    assign m_router_address    = value_out_reg[KIND_ROUTER];
    assign m_dns_address       = value_out_reg[KIND_DNS];
    assign m_lease_seconds     = value_out_reg[KIND_LEASE];
    assign m_server_address    = value_out_reg[KIND_SERVER];
    assign m_renewal_seconds   = value_out_reg[KIND_T1];
    assign m_rebinding_seconds = value_out_reg[KIND_T2];

endmodule

`default_nettype wire

### hdl/dotp_checker.sv
// ----------------------------------------------------------------------------
// dotp_checker
// Port-level checks for the DHCP option parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dotp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_status,
    input wire logic [7:0]  m_message_type
);
    import dotp_pkg::*;

    // no result can come out of reset
    a_idle_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
                                && $stable(m_message_type))
        else $error("stalled result changed");

    // ok status needs a captured message type
    a_ok_has_type: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_OK |-> m_message_type != 8'd0)
        else $error("ok status without message type");

    a_no_type_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_NO_TYPE |-> m_message_type == 8'd0)
        else $error("missing type status with nonzero type");

endmodule

bind dhcp_option_tlv_parser_unit dotp_checker u_dotp_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_message_type (m_message_type)
);

`default_nettype wire

### verif/dhcp_option_tlv_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhcp_option_tlv_parser_unit_tb
// Self-checking bench for the DHCP option parser. A short table of option
// streams hits the framing corners and the error statuses. Random streams
// follow, mostly well framed with random content, some noise and some cut
// short. A local parser model predicts reports the table does not give, and
// reports are checked field by field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module dhcp_option_tlv_parser_unit_tb;
    import dotp_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 6;
    localparam int HOLD_CYCLES     = 64;
    localparam int HOLD_STREAMS    = 10;
    localparam int STALL_LIMIT     = 5000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int DIRECTED_ROWS   = 24;

    typedef enum logic [1:0] {
        WANT_CODE,
        WANT_LEN,
        IN_DATA,
        AFTER_END
    } opt_phase_t;

    typedef struct packed {
        status_t                      status;
        logic [7:0]                   message_type;
        logic [VALUE_SLOTS-1:0][31:0] values;
    } lease_report_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic        given;
        status_t     status;
        logic [7:0]  message_type;
        logic [31:0] subnet_mask;
    } stim_row_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte   = 8'h00;
    logic        s_last_byte   = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [1:0]  m_status;
    logic [7:0]  m_message_type;
    logic [31:0] m_subnet_mask;
    logic [31:0] m_router_address;
    logic [31:0] m_dns_address;
    logic [31:0] m_lease_seconds;
    logic [31:0] m_server_address;
    logic [31:0] m_renewal_seconds;
    logic [31:0] m_rebinding_seconds;

    int          src_idle_pct  = 0;
    int          snk_stall_pct = 0;
    logic        hold_req      = 1'b0;
    int          bytes_sent    = 0;
    int          error_count   = 0;
    int          quiet_cycles  = 0;

    lease_report_t expected_reports [$];
    lease_report_t want;
    logic [7:0]    stream_bytes [$];

    // parser model state
    opt_phase_t  opt_phase   = WANT_CODE;
    logic [7:0]  opt_code    = 8'h00;
    logic [7:0]  opt_len     = 8'h00;
    logic [7:0]  bytes_left  = 8'h00;
    logic [2:0]  bytes_taken = 3'd0;
    logic [31:0] value_acc   = 32'h0;
    logic [7:0]  held_type   = 8'h00;
    logic [31:0] held_values [VALUE_SLOTS] = '{default: 32'h0};

    logic [7:0] slot_codes [VALUE_SLOTS] = '{CODE_SUBNET, CODE_ROUTER, CODE_DNS,
        CODE_LEASE, CODE_SERVER, CODE_T1, CODE_T2};

    // data byte, last, report given, status, message type, subnet mask
    stim_row_t stim_table [DIRECTED_ROWS] = '{
        '{CODE_END,      1'b1, 1'b1, STATUS_NO_TYPE, 8'h00, 32'h0},
        '{CODE_PAD,      1'b1, 1'b1, STATUS_NO_TYPE, 8'h00, 32'h0},
        '{CODE_MSG_TYPE, 1'b1, 1'b1, STATUS_NO_LEN,  8'h00, 32'h0},
        '{CODE_MSG_TYPE, 1'b0, 1'b0, STATUS_OK,      8'h00, 32'h0},
        '{8'h00,         1'b1, 1'b1, STATUS_NO_TYPE, 8'h00, 32'h0},
        '{CODE_SUBNET,   1'b0, 1'b0, STATUS_OK,      8'h00, 32'h0},
        '{8'h04,         1'b0, 1'b0, STATUS_OK,      8'h00, 32'h0},
        '{8'hff,         1'b0, 1'b0, STATUS_OK,      8'h00, 32'h0},
        '{8'hff,         1'b0, 1'b0, STATUS_OK,      8'h00, 32'h0},
        '{8'hff,         1'b1, 1'b1, STATUS_OVERRUN, 8'h00, 32'h0},
        '{CODE_MSG_TYPE, 1'b0, 1'b0, STATUS_OK,      8'h00, 32'h0},
        '{8'h01,         1'b0, 1'b0, STATUS_OK,      8'h00, 32'h0},
        '{8'hff,         1'b0, 1'b0, STATUS_OK,      8'h00, 32'h0},
        '{CODE_SUBNET,   1'b0, 1'b0, STATUS_OK,      8'h00, 32'h0},
        '{8'h04,         1'b0, 1'b0, STATUS_OK,      8'h00, 32'h0},
        '{8'hff,         1'b0, 1'b0, STATUS_OK,      8'h00, 32'h0},
        '{8'hff,         1'b0, 1'b0, STATUS_OK,      8'h00, 32'h0},
        '{8'hff,         1'b0, 1'b0, STATUS_OK,      8'h00, 32'h0},
        '{8'hff,         1'b0, 1'b0, STATUS_OK,      8'h00, 32'h0},
        '{CODE_END,      1'b0, 1'b0, STATUS_OK,      8'h00, 32'h0},
        '{8'h07,         1'b1, 1'b1, STATUS_OK,      8'hff, 32'hffff_ffff},
        '{CODE_MSG_TYPE, 1'b0, 1'b0, STATUS_OK,      8'h00, 32'h0},
        '{8'h01,         1'b0, 1'b0, STATUS_OK,      8'h00, 32'h0},
        '{8'h00,         1'b1, 1'b1, STATUS_NO_TYPE, 8'h00, 32'h0}
    };

    dhcp_option_tlv_parser_unit DUT (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_data_byte         (s_data_byte),
        .s_last_byte         (s_last_byte),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_message_type      (m_message_type),
        .m_subnet_mask       (m_subnet_mask),
        .m_router_address    (m_router_address),
        .m_dns_address       (m_dns_address),
        .m_lease_seconds     (m_lease_seconds),
        .m_server_address    (m_server_address),
        .m_renewal_seconds   (m_renewal_seconds),
        .m_rebinding_seconds (m_rebinding_seconds)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // an option lands only once all its data bytes are in
    task automatic capture_option();
        kind_t slot;
        logic  hit;
        hit  = 1'b1;
        slot = KIND_SUBNET;
        case (opt_code)
            CODE_SUBNET: slot = KIND_SUBNET;
            CODE_ROUTER: slot = KIND_ROUTER;
            CODE_DNS:    slot = KIND_DNS;
            CODE_LEASE:  slot = KIND_LEASE;
            CODE_SERVER: slot = KIND_SERVER;
            CODE_T1:     slot = KIND_T1;
            CODE_T2:     slot = KIND_T2;
            default:     hit = 1'b0;
        endcase
        if (opt_code == CODE_MSG_TYPE) begin
            if (opt_len >= 1 && bytes_taken >= 1)
                held_type = 8'(value_acc >> (8 * (bytes_taken - 1)));
        end else if (hit && opt_len >= 4) begin
            held_values[slot] = value_acc;
        end
    endtask

    task automatic track_byte(input logic [7:0] b, input logic lst,
                              output logic done, output lease_report_t rpt);
        status_t fault;
        fault = STATUS_OK;
        done  = lst;
        rpt   = '0;
        case (opt_phase)
            WANT_CODE: begin
                if (b == CODE_END) begin
                    opt_phase = AFTER_END;
                end else if (b != CODE_PAD) begin
                    opt_code  = b;
                    opt_phase = WANT_LEN;
                    if (lst) fault = STATUS_NO_LEN;
                end
            end
            WANT_LEN: begin
                opt_len     = b;
                bytes_left  = b;
                bytes_taken = 3'd0;
                value_acc   = 32'h0;
                if (b == 8'h00) begin
                    capture_option();
                    opt_phase = WANT_CODE;
                end else begin
                    opt_phase = IN_DATA;
                    if (lst) fault = STATUS_OVERRUN;
                end
            end
            IN_DATA: begin
                if (bytes_taken < 4) begin
                    value_acc   = {value_acc[23:0], b};
                    bytes_taken = bytes_taken + 3'd1;
                end
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 8'h00) begin
                    capture_option();
                    opt_phase = WANT_CODE;
                end else if (lst) begin
                    fault = STATUS_OVERRUN;
                end
            end
            default: ;
        endcase
        if (lst) begin
            if (fault != STATUS_OK)
                rpt.status = fault;
            else if (held_type == 8'h00)
                rpt.status = STATUS_NO_TYPE;
            else
                rpt.status = STATUS_OK;
            rpt.message_type = held_type;
            for (int k = 0; k < VALUE_SLOTS; k++)
                rpt.values[k] = held_values[k];
            // every stream starts from scratch
            opt_phase   = WANT_CODE;
            opt_code    = 8'h00;
            opt_len     = 8'h00;
            bytes_left  = 8'h00;
            bytes_taken = 3'd0;
            value_acc   = 32'h0;
            held_type   = 8'h00;
            held_values = '{default: 32'h0};
        end
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic lst,
                             input logic given, input lease_report_t given_rpt);
        logic          done;
        lease_report_t rpt;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        track_byte(b, lst, done, rpt);
        if (done) expected_reports.push_back(given ? given_rpt : rpt);
        @(negedge aclk);
    endtask

    task automatic build_stream();
        int         n_opts;
        int         len;
        int         r;
        int         pick;
        int         keep;
        logic [7:0] code;
        stream_bytes.delete();
        r = $urandom_range(99);
        if (r < 10) begin
            repeat ($urandom_range(1, 12)) stream_bytes.push_back(8'($urandom));
            return;
        end
        n_opts = $urandom_range(0, 5);
        repeat (n_opts) begin
            pick = $urandom_range(99);
            if (pick < 25)
                code = CODE_MSG_TYPE;
            else if (pick < 80)
                code = slot_codes[$urandom_range(VALUE_SLOTS - 1)];
            else if (pick < 88)
                code = CODE_PAD;
            else
                code = 8'($urandom_range(1, 254));
            stream_bytes.push_back(code);
            if (code != CODE_PAD) begin
                pick = $urandom_range(99);
                if (pick < 60)
                    len = (code == CODE_MSG_TYPE) ? 1 : 4;
                else if (pick < 85)
                    len = $urandom_range(0, 8);
                else if (pick < 97)
                    len = $urandom_range(9, 24);
                else
                    len = $urandom_range(200, 255);
                stream_bytes.push_back(8'(len));
                repeat (len) stream_bytes.push_back(8'($urandom));
            end
        end
        if (r < 55) begin
            stream_bytes.push_back(CODE_END);
            repeat ($urandom_range(0, 4)) stream_bytes.push_back(8'($urandom));
        end else if (r < 85) begin
            if (stream_bytes.size() == 0) stream_bytes.push_back(CODE_PAD);
        end else begin
            // cut the stream short somewhere
            stream_bytes.push_back(8'($urandom));
            keep = $urandom_range(1, stream_bytes.size());
            while (stream_bytes.size() > keep) void'(stream_bytes.pop_back());
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_reports.size() == 0) begin
                $error("report with nothing pending, status %0d", m_status);
                error_count++;
            end else begin
                want = expected_reports.pop_front();
                check_field("status", 32'(want.status), 32'(m_status));
                check_field("message_type", 32'(want.message_type),
                            32'(m_message_type));
                check_field("subnet_mask", want.values[KIND_SUBNET], m_subnet_mask);
                check_field("router_address", want.values[KIND_ROUTER], m_router_address);
                check_field("dns_address", want.values[KIND_DNS], m_dns_address);
                check_field("lease_seconds", want.values[KIND_LEASE], m_lease_seconds);
                check_field("server_address", want.values[KIND_SERVER], m_server_address);
                check_field("renewal_seconds", want.values[KIND_T1], m_renewal_seconds);
                check_field("rebinding_seconds", want.values[KIND_T2],
                            m_rebinding_seconds);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver: random stalls, plus one long hold on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    initial begin
        lease_report_t given_rpt;
        int            phase_no;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            given_rpt                     = '0;
            given_rpt.status              = stim_table[i].status;
            given_rpt.message_type        = stim_table[i].message_type;
            given_rpt.values[KIND_SUBNET] = stim_table[i].subnet_mask;
            send_byte(stim_table[i].data_byte, stim_table[i].last_byte,
                      stim_table[i].given, given_rpt);
        end

        for (phase_no = 0; phase_no < 4; phase_no++) begin
            case (phase_no)
                0: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1: begin
                    src_idle_pct  = 51;
                    snk_stall_pct = 0;
                end
                2: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 51;
                end
                default: begin
                    src_idle_pct  = 14;
                    snk_stall_pct = 14;
                end
            endcase
            if (phase_no == 0) begin
                // one-byte streams pile up reports while the receiver holds off
                hold_req = 1'b1;
                repeat (HOLD_STREAMS) send_byte(8'($urandom), 1'b1, 1'b0, '0);
            end
            bytes_sent = 0;
            while (bytes_sent < ITEMS_PER_PHASE) begin
                build_stream();
                foreach (stream_bytes[j])
                    send_byte(stream_bytes[j], j == stream_bytes.size() - 1, 1'b0, '0);
            end
            s_valid <= 1'b0;
            while (expected_reports.size() != 0) @(posedge aclk);
            @(negedge aclk);
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### sim.f
hdl/dotp_pkg.sv
hdl/dotp_front.sv
hdl/dotp_queue.sv
hdl/dotp_back.sv
hdl/dhcp_option_tlv_parser_unit.sv
hdl/dotp_checker.sv
verif/dhcp_option_tlv_parser_unit_tb.sv
